/* sv/sha256_pkg.sv */
// SHA-256 package: payload structs, round constants, helper functions.
// No dependencies; used by every module of sha256_stream_hasher.
`timescale 1ns / 1ps
package sha256_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_item_t;

	localparam int unsigned QueueDepthDefault = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_PAD,
		ST_COMP,
		ST_EMIT
	} back_state_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

/* sv/sha256_queue.sv */
// Small FIFO between the input front and the hashing back end.
// Depends on sha256_pkg for the item struct.
`timescale 1ns / 1ps
module sha256_queue #(
	parameter int unsigned DEPTH = sha256_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  sha256_pkg::in_item_t wr_item,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output sha256_pkg::in_item_t rd_item
);
	import sha256_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t          mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (AW+1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("count did not advance on push");

endmodule

/* sv/sha256_core.sv */
// Back end: packs bytes, pads, runs the 64-round compression one round a
// cycle, and emits the eight digest words. Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  sha256_pkg::in_item_t  item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output sha256_pkg::out_item_t res
);
	import sha256_pkg::*;

	back_state_t  state_q, state_d;
	logic [31:0]  hash_q [8];
	logic [31:0]  w_q    [16];
	logic [31:0]  v_q    [8];
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [5:0]   round_q;
	logic         eom_q;     // finish after current work
	logic         last_q;    // compression under way is the final one
	logic [2:0]   widx_q;

	// Round datapath
	logic [31:0] wt, t1, t2, w_new;
	assign wt    = w_q[0];
	assign t1    = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[round_q] + wt;
	assign t2    = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));
	assign w_new = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);

	// Byte written this cycle in ST_BYTE / ST_PAD
	logic [7:0]  wbyte;
	logic        wr_en;
	logic        go_comp;
	logic        pad_len;   // pad state writes length and compresses

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_EMIT);
	assign res.digest_word = hash_q[widx_q];
	assign res.word_index  = widx_q;
	assign res.digest_last = (widx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = item.byte_present ? ST_BYTE : (item.end_of_message ? ST_PAD : ST_IDLE);
				end
			end
			ST_BYTE: begin
				if (fill_q == 6'd63) begin
					state_d = ST_COMP;
				end else begin
					state_d = eom_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				if (pad_len || fill_q == 6'd63) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (round_q == 6'd63) begin
					state_d = last_q ? ST_EMIT : (eom_q ? ST_PAD : ST_IDLE);
				end
			end
			ST_EMIT: begin
				if (res_ready && widx_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pad_q marks that the 0x80 byte is already placed
	logic pad_q;
	always_comb begin
		wbyte   = '0;
		wr_en   = 1'b0;
		pad_len = 1'b0;
		go_comp = 1'b0;
		case (state_q)
			ST_BYTE: begin
				wbyte = item.msg_byte;
				wr_en = 1'b1;
				go_comp = (fill_q == 6'd63);
			end
			ST_PAD: begin
				wbyte   = pad_q ? 8'h00 : PAD_BYTE;
				pad_len = pad_q && (fill_q == LEN_OFFSET);
				wr_en   = !pad_len;
				go_comp = pad_len || (fill_q == 6'd63);
			end
			default: ;
		endcase
	end

	// Byte staged in ST_BYTE: hold item byte in a register
	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			byte_q <= item.msg_byte;
		end
		if (wr_en) begin
			case (fill_q[1:0])
				2'd0: w_q[fill_q[5:2]][31:24] <= (state_q == ST_BYTE) ? byte_q : wbyte;
				2'd1: w_q[fill_q[5:2]][23:16] <= (state_q == ST_BYTE) ? byte_q : wbyte;
				2'd2: w_q[fill_q[5:2]][15:8]  <= (state_q == ST_BYTE) ? byte_q : wbyte;
				default: w_q[fill_q[5:2]][7:0] <= (state_q == ST_BYTE) ? byte_q : wbyte;
			endcase
		end
		if (pad_len) begin
			w_q[14] <= bits_q[63:32];
			w_q[15] <= bits_q[31:0];
		end
		if (go_comp) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			round_q <= '0;
			eom_q   <= 1'b0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			widx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && item_valid) begin
				eom_q <= item.end_of_message;
			end
			if (state_q == ST_BYTE) begin
				bits_q <= bits_q + 64'd8;
			end
			if (wr_en) begin
				fill_q <= fill_q + 1'b1;
				if (state_q == ST_PAD) begin
					pad_q <= 1'b1;
				end
			end
			if (pad_len) begin
				fill_q <= '0;
				last_q <= 1'b1;
			end
			if (go_comp) begin
				round_q <= '0;
			end else if (state_q == ST_COMP) begin
				round_q <= round_q + 1'b1;
				if (round_q == 6'd63) begin
					hash_q[0] <= hash_q[0] + t1 + t2;
					hash_q[1] <= hash_q[1] + v_q[0];
					hash_q[2] <= hash_q[2] + v_q[1];
					hash_q[3] <= hash_q[3] + v_q[2];
					hash_q[4] <= hash_q[4] + v_q[3] + t1;
					hash_q[5] <= hash_q[5] + v_q[4];
					hash_q[6] <= hash_q[6] + v_q[5];
					hash_q[7] <= hash_q[7] + v_q[6];
				end
			end
			if (state_q == ST_EMIT && res_ready) begin
				widx_q <= widx_q + 1'b1;
				if (widx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= H_INIT[i];
					end
					fill_q <= '0;
					bits_q <= '0;
					eom_q  <= 1'b0;
					last_q <= 1'b0;
					pad_q  <= 1'b0;
				end
			end
		end
	end

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT) |-> (widx_q == 3'd0))
		else $error("word index not cleared outside emit");
	a_comp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && round_q != 6'd63) |=> (state_q == ST_COMP))
		else $error("compression left early");
	a_last_pad: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> pad_q)
		else $error("final block without pad byte");

endmodule

/* sv/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: input queue and hashing core.
// Depends on sha256_pkg, sha256_queue, sha256_core.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | sha256_pkg::in_item_t
//   out     | output    | out_valid / out_ready| sha256_pkg::out_item_t
//
// A plain byte passes through ST_IDLE and ST_BYTE; a byte that fills a block
// adds 64 compression rounds, one round per cycle in the shared round unit.
// End of message pads 0x80, then a zero byte per cycle up to the length field,
// runs one or two compressions, then emits eight words, one per accepted cycle.
// arst_n clears control state and loads the initial hash.
// The input queue takes items until full while the core is busy or out stalls.
`timescale 1ns / 1ps
module sha256_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepthDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	logic     q_valid;
	logic     q_ready;
	in_item_t q_item;

	// Front: buffer incoming transactions.
	sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_item  (in_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// Back: pack, pad, compress, emit.
	sha256_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (out_item)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("out transaction dropped");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.digest_last) |-> (out_item.word_index == 3'd7))
		else $error("last flag off word seven");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("in transaction dropped");

endmodule
